[hw/rtl/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// Types, codes and constants shared by the circular deque unit.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int DepthDefault = 16;
   localparam int WordW        = 32;
   localparam int CountW       = 5;
   localparam int CsrAddrW     = 3;
   localparam int CsrDataW     = 32;

   localparam logic [CountW-1:0] CapReset = 5'd16;

   typedef enum logic [1:0] {
      MODE_PUSH_FRONT = 2'd0,
      MODE_PUSH_BACK  = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_BACK   = 2'd3
   } cdq_mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } cdq_status_type;

   typedef struct packed {
      logic [1:0]              mode;
      logic signed [WordW-1:0] value;
   } cdq_req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [WordW-1:0] popped_value;
      logic [CountW-1:0]       item_count;
      logic                    is_empty;
      logic                    is_full;
   } cdq_rsp_type;

   typedef struct packed {
      logic              clear;
      logic [CountW-1:0] eff_cap;
   } cdq_cfg_type;

endpackage

[hw/rtl/circular_deque_unit.sv]
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue of 32-bit words in a circular store.
//
// req_payload carries mode (push front, push back, pop front, pop back) and
// the word to push. One transfer on rsp_payload answers every request
// transfer, in order: status, popped word, count and empty/full flags.
// A request transfer is taken when req_valid is high and req_stall low;
// requests are accepted one per cycle. The pointer update and the store
// access happen in the accepting cycle; a pop's word comes from the store's
// registered read in the next cycle and goes on to the result register,
// which holds while rsp_stall is high; one further request may then be
// taken into the read stage before req_stall rises. After reset the deque
// is empty, capacity reads 16 and no result is pending. Write the capacity
// register at byte 0 only while the unit is idle; the block does not enforce
// this. A write empties the deque. No clearing pass is needed.
// ----------------------------------------------------------------------------
module circular_deque_unit #(
   parameter int DEPTH = cdq_pkg::DepthDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  cdq_pkg::cdq_req_type             req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output cdq_pkg::cdq_rsp_type             rsp_payload,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [cdq_pkg::CsrAddrW-1:0]     paddr,
   input  logic [cdq_pkg::CsrDataW-1:0]     pwdata,
   output logic [cdq_pkg::CsrDataW-1:0]     prdata,
   output logic                             pready
);
   import cdq_pkg::*;

   localparam int IdxW = $clog2(DEPTH);

   cdq_cfg_type      cfg;
   logic             mem_wr_en, mem_rd_en;
   logic [IdxW-1:0]  mem_wr_addr, mem_rd_addr;
   logic [WordW-1:0] mem_wr_data, mem_rd_data;

   cdq_csr #(.DEPTH(DEPTH)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   cdq_mem #(.DEPTH(DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

[hw/rtl/cdq_mem.sv]
// ----------------------------------------------------------------------------
// cdq_mem
// Word store of the deque: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cdq_mem #(
   parameter int DEPTH = cdq_pkg::DepthDefault
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [cdq_pkg::WordW-1:0]         wr_data,
   input  logic                              rd_en,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [cdq_pkg::WordW-1:0]         rd_data
);
   import cdq_pkg::*;

   logic [WordW-1:0] store_ff [DEPTH];
   logic [WordW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/cdq_csr.sv]
// ----------------------------------------------------------------------------
// cdq_csr
// Capacity register behind the APB-style port; clamps it for the datapath.
// ----------------------------------------------------------------------------
module cdq_csr #(
   parameter int DEPTH = cdq_pkg::DepthDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [cdq_pkg::CsrAddrW-1:0]     paddr,
   input  logic [cdq_pkg::CsrDataW-1:0]     pwdata,
   output logic [cdq_pkg::CsrDataW-1:0]     prdata,
   output logic                             pready,
   output cdq_pkg::cdq_cfg_type             cfg
);
   import cdq_pkg::*;

   localparam int CapMax = (DEPTH < 31) ? DEPTH : 31;
   localparam logic [CountW-1:0] CapMaxW = CountW'(CapMax);

   function automatic logic [CountW-1:0] clamp_cap(input logic [CountW-1:0] c);
      logic [CountW-1:0] r;
      r = c;
      if (c == '0) begin
         r = CountW'(1);
      end else if (c > CapMaxW) begin
         r = CapMaxW;
      end
      return r;
   endfunction

   logic [CountW-1:0] capacity_ff, capacity_in;
   logic [CountW-1:0] eff_cap_ff, eff_cap_in;
   logic              hit;
   logic              wr;

   assign hit = (paddr[CsrAddrW-1] == 1'b0);
   assign wr  = psel & penable & pwrite & pready & hit;

   assign capacity_in = wr ? pwdata[CountW-1:0] : capacity_ff;
   assign eff_cap_in  = wr ? clamp_cap(pwdata[CountW-1:0]) : eff_cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CapReset;
         eff_cap_ff  <= clamp_cap(CapReset);
      end else begin
         capacity_ff <= capacity_in;
         eff_cap_ff  <= eff_cap_in;
      end
   end

   assign pready      = 1'b1;
   assign prdata      = hit ? CsrDataW'(capacity_ff) : '0;
   assign cfg.clear   = wr;
   assign cfg.eff_cap = eff_cap_ff;

endmodule

[hw/rtl/cdq_ctrl.sv]
// ----------------------------------------------------------------------------
// cdq_ctrl
// Pointer and occupancy logic, store access, read stage and result register.
// ----------------------------------------------------------------------------
module cdq_ctrl #(
   parameter int DEPTH = cdq_pkg::DepthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cdq_pkg::cdq_cfg_type              cfg,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  cdq_pkg::cdq_req_type              req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output cdq_pkg::cdq_rsp_type              rsp_payload,
   output logic                              mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]          mem_wr_addr,
   output logic [cdq_pkg::WordW-1:0]         mem_wr_data,
   output logic                              mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]          mem_rd_addr,
   input  logic [cdq_pkg::WordW-1:0]         mem_rd_data
);
   import cdq_pkg::*;

   localparam int IdxW = $clog2(DEPTH);
   localparam int CmpW = ((IdxW > CountW) ? IdxW : CountW) + 1;

   logic [IdxW-1:0]   front_ff, front_in;
   logic [IdxW-1:0]   rear_ff, rear_in;
   logic [CountW-1:0] occ_ff, occ_in;

   logic              s1_valid_ff, s1_valid_in;
   logic [1:0]        s1_status_ff, s1_status_in;
   logic              s1_pop_ff, s1_pop_in;
   logic [CountW-1:0] s1_count_ff, s1_count_in;
   logic              s1_full_ff, s1_full_in;

   logic              out_valid_ff, out_valid_in;
   cdq_rsp_type       out_ff, out_in;

   logic              acc, s1_adv, is_push, empty, full, from_front;
   logic [IdxW-1:0]   front_prev, front_next, rear_prev, rear_next;
   logic [IdxW-1:0]   cap_last;

   assign cap_last   = IdxW'(cfg.eff_cap - CountW'(1));
   assign front_prev = (front_ff == '0) ? cap_last : front_ff - IdxW'(1);
   assign rear_prev  = (rear_ff == '0) ? cap_last : rear_ff - IdxW'(1);
   assign front_next = (CmpW'(front_ff) + CmpW'(1) >= CmpW'(cfg.eff_cap)) ?
                       '0 : front_ff + IdxW'(1);
   assign rear_next  = (CmpW'(rear_ff) + CmpW'(1) >= CmpW'(cfg.eff_cap)) ?
                       '0 : rear_ff + IdxW'(1);

   assign s1_adv    = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign acc       = req_valid && !req_stall;

   assign is_push    = (req_payload.mode == MODE_PUSH_FRONT) ||
                       (req_payload.mode == MODE_PUSH_BACK);
   assign from_front = (req_payload.mode == MODE_PUSH_FRONT) ||
                       (req_payload.mode == MODE_POP_FRONT);
   assign empty      = (occ_ff == '0);
   assign full       = (occ_ff >= cfg.eff_cap);

   always_comb begin
      front_in     = front_ff;
      rear_in      = rear_ff;
      occ_in       = occ_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = front_prev;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = from_front ? front_ff : rear_ff;
      s1_status_in = STATUS_DONE;
      s1_pop_in    = 1'b0;
      if (cfg.clear) begin
         front_in = '0;
         rear_in  = '0;
         occ_in   = '0;
      end else if (acc) begin
         if (is_push) begin
            if (full) begin
               s1_status_in = STATUS_OVERFLOW;
            end else begin
               mem_wr_en = 1'b1;
               occ_in    = occ_ff + CountW'(1);
               if (empty) begin
                  mem_wr_addr = '0;
                  front_in    = '0;
                  rear_in     = '0;
               end else if (from_front) begin
                  mem_wr_addr = front_prev;
                  front_in    = front_prev;
               end else begin
                  mem_wr_addr = rear_next;
                  rear_in     = rear_next;
               end
            end
         end else begin
            if (empty) begin
               s1_status_in = STATUS_UNDERFLOW;
            end else begin
               mem_rd_en = 1'b1;
               s1_pop_in = 1'b1;
               occ_in    = occ_ff - CountW'(1);
               if (occ_ff == CountW'(1)) begin
                  front_in = '0;
                  rear_in  = '0;
               end else if (from_front) begin
                  front_in = front_next;
               end else begin
                  rear_in = rear_prev;
               end
            end
         end
      end
   end

   assign mem_wr_data = req_payload.value;

   assign s1_valid_in = acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign s1_count_in = occ_in;
   assign s1_full_in  = (occ_in == cfg.eff_cap);

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in        = s1_valid_ff;
         out_in.status       = s1_status_ff;
         out_in.popped_value = s1_pop_ff ? mem_rd_data : '0;
         out_in.item_count   = s1_count_ff;
         out_in.is_empty     = (s1_count_ff == '0);
         out_in.is_full      = s1_full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         rear_ff      <= '0;
         occ_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         occ_ff       <= occ_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_status_ff <= s1_status_in;
         s1_pop_ff    <= s1_pop_in;
         s1_count_ff  <= s1_count_in;
         s1_full_ff   <= s1_full_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= cfg.eff_cap)
      else $error("occupancy above capacity");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (CmpW'(front_ff) < CmpW'(cfg.eff_cap)) && (CmpW'(rear_ff) < CmpW'(cfg.eff_cap)))
      else $error("pointer beyond capacity");

   a_overflow_hold: assert property (@(posedge clock) disable iff (reset)
      acc && is_push && full && !cfg.clear |=> $stable(occ_ff) && $stable(front_ff)
      && $stable(rear_ff))
      else $error("overflowing push changed the deque");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   a_pop_read: assert property (@(posedge clock) disable iff (reset)
      mem_rd_en |-> !mem_wr_en && !empty)
      else $error("store read on an empty deque");

endmodule
